[design/smepc_pkg.sv]
// ----------------------------------------------------------------------------
// smepc_pkg
// Shared types, codes and the quarter-wave sine table of the step morph
// crossfader.
// ----------------------------------------------------------------------------
`default_nettype none

package smepc_pkg;

  // Action codes carried in tuser
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BEATS   = 2'd0,
    CFG_UNIT    = 2'd1,
    CFG_STEPS   = 2'd2,
    CFG_SOURCES = 2'd3
  } cfg_idx_t;

  // One pipeline slot
  typedef struct packed {
    logic             vld;
    logic             act;
    logic [4:0]       widx;
    logic [15:0]      wval;
    logic [7:0][23:0] smp;    // left0, right0, left1, right1, ...
    logic [35:0]      qh;     // scaled position, upper part
    logic [17:0]      ql;     // scaled position, lower 18 bits
    logic [5:0]       mr;     // running bar remainder
    logic [23:0]      rem;    // divider remainder
    logic [4:0]       xl;     // low dividend bits still to shift in
    logic [20:0]      quo;    // {step, frac}
    logic [15:0]      morph;
    logic [2:0]       tot;    // sources in use
    logic [1:0]       lsel;   // left source of the pair
    logic [15:0]      g;
    logic [15:0]      gc;
    logic [15:0]      gs;
    logic [1:0][41:0] pa;     // left source products per channel
    logic [1:0][41:0] pb;     // right source products per channel
  } slot_t;

  function automatic logic [15:0] sine_tab(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0:  v = 16'd0;
      6'd1:  v = 16'd1608;
      6'd2:  v = 16'd3212;
      6'd3:  v = 16'd4808;
      6'd4:  v = 16'd6393;
      6'd5:  v = 16'd7962;
      6'd6:  v = 16'd9512;
      6'd7:  v = 16'd11039;
      6'd8:  v = 16'd12540;
      6'd9:  v = 16'd14010;
      6'd10: v = 16'd15447;
      6'd11: v = 16'd16846;
      6'd12: v = 16'd18205;
      6'd13: v = 16'd19520;
      6'd14: v = 16'd20788;
      6'd15: v = 16'd22006;
      6'd16: v = 16'd23170;
      6'd17: v = 16'd24279;
      6'd18: v = 16'd25330;
      6'd19: v = 16'd26320;
      6'd20: v = 16'd27246;
      6'd21: v = 16'd28106;
      6'd22: v = 16'd28899;
      6'd23: v = 16'd29622;
      6'd24: v = 16'd30274;
      6'd25: v = 16'd30853;
      6'd26: v = 16'd31357;
      6'd27: v = 16'd31786;
      6'd28: v = 16'd32138;
      6'd29: v = 16'd32413;
      6'd30: v = 16'd32610;
      6'd31: v = 16'd32729;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  // Interpolated quarter-wave sine, 11 fraction bits per interval
  function automatic logic [15:0] sinq(input logic [16:0] x);
    logic [5:0]  i;
    logic [10:0] fr;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [21:0] p;
    i  = x[16:11];
    fr = x[10:0];
    lo = sine_tab(i);
    hi = sine_tab(i + 6'd1);
    p  = 22'((hi - lo) & 16'h07FF) * 22'(fr);
    if (i >= 6'd32) begin
      return 16'd32768;
    end
    return lo + 16'(p[21:11]);
  endfunction

endpackage

`default_nettype wire

[design/smepc_step_ram.sv]
// ----------------------------------------------------------------------------
// smepc_step_ram
// Step table: one write port, two registered read ports, per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module smepc_step_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [15:0]   rdata_a,
  output logic      [15:0]   rdata_b
);
  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[waddr] <= wdata;
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en && we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Registered reads, held while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a <= vld_r[raddr_a] ? mem[raddr_a] : 16'd0;
      rdata_b <= vld_r[raddr_b] ? mem[raddr_b] : 16'd0;
    end
  end

endmodule

`default_nettype wire

[design/step_morph_equal_power_crossfade.sv]
// ----------------------------------------------------------------------------
// step_morph_equal_power_crossfade
// Step-sequenced equal-power morph across up to four stereo sources.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects the action (0 loads one step table word,
//   1 processes one stereo sample); tdata carries position, step index,
//   step value and the eight source samples. Every input transaction gives
//   exactly one output transaction (out_left, out_right, morph_value), zero
//   samples and morph for step writes.
//   Throughput: one transaction per clock while in_tready is high. The
//   pipeline runs through the bar fold (7 stages, 5 remainder bits each),
//   the 21-stage restoring divider that yields the step and fraction,
//   the step table read and the gain and mix stages.
//   The step table has two read ports and one write port on the same stage,
//   so a write is seen by every later sample.
//   Reset clears the pipeline, the output register and the table valid bits
//   at once; no clearing pass. Config regs return to 4/4, 4 steps, 2 sources.
//   When the receiver stalls, the result holds in the output register; the
//   pipeline keeps advancing into its empty slots and in_tready drops only
//   when the last stage holds a result behind the stalled output.
//   Configuration is to be written through cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module step_morph_equal_power_crossfade #(
  parameter int MAX_SOURCES = 4,
  parameter int MAX_STEPS   = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // position[47:0], step_index[52:48], step_value[68:53], src0_left[92:69],
  // src0_right[116:93], src1_left[140:117], src1_right[164:141],
  // src2_left[188:165], src2_right[212:189], src3_left[236:213],
  // src3_right[260:237], zero pad[263:261]
  input  wire logic [263:0] in_tdata,
  // action[0]
  input  wire logic         in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_left[23:0], out_right[47:24], morph_value[63:48]
  output logic      [63:0]  out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [5:0]   cfg_wdata
);
  import smepc_pkg::*;

  localparam int AW      = $clog2(MAX_STEPS);
  localparam int MOD_STG = 7;
  localparam int DIV_STG = 21;
  localparam int P_X     = MOD_STG + 1;
  localparam int P_DIV0  = P_X + 1;
  localparam int P_RD    = P_DIV0 + DIV_STG;
  localparam int P_MRF   = P_RD + 1;
  localparam int P_SEL   = P_MRF + 1;
  localparam int P_GAIN  = P_SEL + 1;
  localparam int P_PROD  = P_GAIN + 1;
  localparam int NST     = P_PROD + 1;
  localparam int SRC_LIM = (MAX_SOURCES < 4) ? MAX_SOURCES : 4;

  logic [5:0] beats_r;
  logic [5:0] unit_r;
  logic [5:0] steps_r;
  logic [2:0] srcs_r;

  slot_t pipe_r   [NST];
  slot_t pipe_nxt [NST];

  logic        adv;
  logic [5:0]  num;
  logic [5:0]  den;
  logic [5:0]  s_pow;
  logic [5:0]  s_cnt;
  logic [23:0] modv;
  logic [2:0]  tot;

  logic [15:0] rd_a;
  logic [15:0] rd_b;
  logic [4:0]  rd_step;
  logic [5:0]  rd_stp1;
  logic [5:0]  rd_next;
  logic        wr_en;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [63:0] out_data_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beats_r <= 6'd4;
      unit_r  <= 6'd4;
      steps_r <= 6'd4;
      srcs_r  <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_BEATS:   beats_r <= cfg_wdata;
        CFG_UNIT:    unit_r  <= cfg_wdata;
        CFG_STEPS:   steps_r <= cfg_wdata;
        CFG_SOURCES: srcs_r  <= cfg_wdata[2:0];
        default:     beats_r <= beats_r;
      endcase
    end
  end

  // Derived settings; the user keeps them static while items are in flight, the block does not enforce it
  always_comb begin
    num   = (beats_r == 6'd0) ? 6'd1 : beats_r;
    den   = (unit_r == 6'd0) ? 6'd1 : unit_r;
    s_pow = (steps_r >= 6'd32) ? 6'd32 : (steps_r >= 6'd16) ? 6'd16 :
            (steps_r >= 6'd8) ? 6'd8 : 6'd4;
    s_cnt = (s_pow > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : s_pow;
    modv  = {num, 18'd0};
    tot   = (srcs_r > 3'(SRC_LIM)) ? 3'(SRC_LIM) : srcs_r;
  end

  // Advance unless a finished result sits behind a stalled output
  assign adv       = !pipe_r[NST-1].vld || !out_valid_r || out_tready;
  assign in_tready = adv;

  // Stage 0: capture and scale the position by the denominator
  always_comb begin
    logic signed [54:0] qf;
    qf = $signed(in_tdata[47:0]) * $signed({1'b0, den});
    pipe_nxt[0]       = '0;
    pipe_nxt[0].vld   = in_tvalid;
    pipe_nxt[0].act   = in_tuser;
    pipe_nxt[0].widx  = in_tdata[52:48];
    pipe_nxt[0].wval  = in_tdata[68:53];
    pipe_nxt[0].smp   = in_tdata[260:69];
    pipe_nxt[0].qh    = qf[53:18];
    pipe_nxt[0].ql    = qf[17:0];
    // sign bit weighs minus one in the bar fold
    pipe_nxt[0].mr    = qf[53] ? (num - 6'd1) : 6'd0;
  end

  // Bar fold: remainder of the upper part modulo the numerator
  for (genvar k = 1; k <= MOD_STG; k++) begin : g_mod
    always_comb begin
      logic [6:0] t;
      logic [5:0] r;
      r = pipe_r[k-1].mr;
      for (int b = 0; b < 5; b++) begin
        t = {r, pipe_r[k-1].qh[34 - 5*(k-1) - b]};
        if (t >= {1'b0, num}) begin
          t = t - {1'b0, num};
        end
        r = t[5:0];
      end
      pipe_nxt[k]    = pipe_r[k-1];
      pipe_nxt[k].mr = r;
    end
  end

  // Scale the bar phase by the step count and seed the divider
  always_comb begin
    logic [29:0] x;
    x = {pipe_r[P_X-1].mr, pipe_r[P_X-1].ql} * s_cnt;
    pipe_nxt[P_X]     = pipe_r[P_X-1];
    pipe_nxt[P_X].rem = x[28:5];
    pipe_nxt[P_X].xl  = x[4:0];
    pipe_nxt[P_X].quo = '0;
  end

  // Restoring divider: one quotient bit per stage, low dividend bits
  // shift in from the top of xl, zeros after them
  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    always_comb begin
      logic [24:0] t;
      logic        qb;
      t  = {pipe_r[P_DIV0+j-1].rem, pipe_r[P_DIV0+j-1].xl[4]};
      qb = (t >= {1'b0, modv});
      if (qb) begin
        t = t - {1'b0, modv};
      end
      pipe_nxt[P_DIV0+j]     = pipe_r[P_DIV0+j-1];
      pipe_nxt[P_DIV0+j].rem = t[23:0];
      pipe_nxt[P_DIV0+j].xl  = {pipe_r[P_DIV0+j-1].xl[3:0], 1'b0};
      pipe_nxt[P_DIV0+j].quo = {pipe_r[P_DIV0+j-1].quo[19:0], qb};
    end
  end

  // Step table access: writes and reads share one stage
  always_comb begin
    rd_step = pipe_r[P_RD-1].quo[20:16];
    rd_stp1 = {1'b0, rd_step} + 6'd1;
    rd_next = (rd_stp1 == s_cnt) ? 6'd0 : rd_stp1;
    wr_en   = pipe_r[P_RD-1].vld && (pipe_r[P_RD-1].act == ACT_WRITE) &&
              ({1'b0, pipe_r[P_RD-1].widx} < 6'(MAX_STEPS));
    pipe_nxt[P_RD] = pipe_r[P_RD-1];
  end

  smepc_step_ram #(
    .DEPTH (MAX_STEPS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .we      (wr_en),
    .waddr   (pipe_r[P_RD-1].widx[AW-1:0]),
    .wdata   (pipe_r[P_RD-1].wval),
    .raddr_a (rd_step[AW-1:0]),
    .raddr_b (rd_next[AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Interpolate the morph value between neighboring steps
  always_comb begin
    logic signed [16:0] diff;
    logic signed [33:0] pm;
    logic signed [17:0] sum;
    diff = $signed({1'b0, rd_b}) - $signed({1'b0, rd_a});
    pm   = diff * $signed({1'b0, pipe_r[P_MRF-1].quo[15:0]});
    sum  = $signed({2'b0, rd_a}) + 18'(pm >>> 16);
    pipe_nxt[P_MRF]       = pipe_r[P_MRF-1];
    pipe_nxt[P_MRF].morph = (pipe_r[P_MRF-1].act == ACT_WRITE) ? 16'd0 : sum[15:0];
  end

  // Pick the source pair and the fade position
  always_comb begin
    logic [1:0]  tm1;
    logic [17:0] x;
    logic [1:0]  lft;
    tm1 = (tot >= 3'd2) ? 2'(tot - 3'd1) : 2'd0;
    x   = pipe_r[P_SEL-1].morph * tm1;
    lft = x[17:16];
    if ((tot >= 3'd2) && ({1'b0, lft} > (tot - 3'd2))) begin
      lft = 2'(tot - 3'd2);
    end
    pipe_nxt[P_SEL]      = pipe_r[P_SEL-1];
    pipe_nxt[P_SEL].tot  = tot;
    pipe_nxt[P_SEL].lsel = lft;
    pipe_nxt[P_SEL].g    = x[15:0];
  end

  // Equal-power gains
  always_comb begin
    pipe_nxt[P_GAIN]    = pipe_r[P_GAIN-1];
    pipe_nxt[P_GAIN].gc = sinq(17'h10000 - {1'b0, pipe_r[P_GAIN-1].g});
    pipe_nxt[P_GAIN].gs = sinq({1'b0, pipe_r[P_GAIN-1].g});
  end

  // Weight both sources of the pair, per channel
  always_comb begin
    logic [2:0] ia;
    logic [2:0] ib;
    pipe_nxt[P_PROD] = pipe_r[P_PROD-1];
    for (int ch = 0; ch < 2; ch++) begin
      ia = {pipe_r[P_PROD-1].lsel, 1'(ch)};
      ib = {pipe_r[P_PROD-1].lsel + 2'd1, 1'(ch)};
      pipe_nxt[P_PROD].pa[ch] = 42'($signed(pipe_r[P_PROD-1].smp[ia]) *
                                    $signed({2'b0, pipe_r[P_PROD-1].gc}));
      pipe_nxt[P_PROD].pb[ch] = 42'($signed(pipe_r[P_PROD-1].smp[ib]) *
                                    $signed({2'b0, pipe_r[P_PROD-1].gs}));
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        pipe_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  // Mix, floor, saturate; a single source passes through, no sources and step writes give zero
  always_comb begin
    logic signed [42:0] sum;
    logic signed [42:0] sh;
    logic [23:0]        mix [2];
    slot_t              s;
    s = pipe_r[NST-1];
    for (int ch = 0; ch < 2; ch++) begin
      sum = 43'($signed(s.pa[ch])) + 43'($signed(s.pb[ch]));
      sh  = sum >>> 15;
      if (sh > 43'sd8388607) begin
        mix[ch] = 24'h7FFFFF;
      end else if (sh < -43'sd8388608) begin
        mix[ch] = 24'h800000;
      end else begin
        mix[ch] = sh[23:0];
      end
      if (s.tot == 3'd1) begin
        mix[ch] = s.smp[ch];
      end else if (s.tot == 3'd0) begin
        mix[ch] = 24'd0;
      end
    end
    if (s.act == ACT_WRITE) begin
      out_data_nxt = 64'd0;
    end else begin
      out_data_nxt = {s.morph, mix[1], mix[0]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= pipe_r[NST-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[design/smepc_checker.sv]
// ----------------------------------------------------------------------------
// smepc_checker
// Port-level checks of the step morph crossfader, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smepc_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // An empty output register never back-pressures the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A draining output register never back-pressures the input
  a_ready_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind step_morph_equal_power_crossfade smepc_checker u_smepc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
